/* sv/ssrb_pkg.sv */
// shared types, register indexes and colour widening for the scaled sprite run blitter
// no dependencies; imported by ssrb_dp, ssrb_ctrl and the top level
package ssrb_pkg;

  localparam int SPAN_W     = 11;
  localparam int COORD_W    = 12;
  localparam int OUT_XY_W   = 13;
  localparam int SIZE_W     = 11;
  localparam int PIX_W      = 16;
  localparam int RGB_W      = 24;
  localparam int SRC_DIM_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_SPAN_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_SPAN_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_COLS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ROWS    = 3'd5;

  // which scaled edge the shared divider is working on
  typedef logic [2:0] op_t;
  localparam op_t OP_TOP   = 3'd0;  // row
  localparam op_t OP_BOT   = 3'd1;  // row + 1
  localparam op_t OP_START = 3'd2;  // open run's first column
  localparam op_t OP_COL   = 3'd3;  // current column
  localparam op_t OP_COL1  = 3'd4;  // current column + 1

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_DIV    = 5'b00100,
    S_EMIT_A = 5'b01000,
    S_EMIT_B = 5'b10000
  } state_t;

  typedef struct packed {
    logic take;    // capture the accepted pixel
    logic load;    // form dividend and start a division
    logic step;    // one radix-4 divider step
    logic store;   // keep the finished quotient
    op_t  op;
    logic emit_a;  // load output with the run closed by a colour change
    logic emit_b;  // load output with the run ended by the row end
    logic update;  // advance counters and run state
  } dp_cmd_t;

  typedef struct packed {
    logic vis_a;
    logic vis_b;
    logic out_free;
  } dp_sts_t;

  // x*255/31 = 8x + floor(7x/31), the small quotient by reciprocal
  function automatic logic [7:0] widen5(logic [4:0] x);
    logic [8:0] y;
    logic [8:0] s;
    y = {1'b0, x, 3'b000} - {4'b0000, x};
    s = y + (y >> 5) + 9'd1;
    return {x, 3'b000} + {5'b00000, s[7:5]};
  endfunction

  // x*255/63 = 4x + floor(x/21)
  function automatic logic [7:0] widen6(logic [5:0] x);
    logic [1:0] k;
    if (x >= 6'd63) k = 2'd3;
    else if (x >= 6'd42) k = 2'd2;
    else if (x >= 6'd21) k = 2'd1;
    else k = 2'd0;
    return {x, 2'b00} + {6'b000000, k};
  endfunction

  function automatic logic [RGB_W-1:0] widen565(logic [PIX_W-1:0] c);
    return {widen5(c[15:11]), widen6(c[10:5]), widen5(c[4:0])};
  endfunction

endpackage

/* sv/ssrb_div.sv */
// iterative restoring divider, two quotient bits per cycle while step is high
// standalone; used by ssrb_dp for the scaled edge positions
module ssrb_div #(
  parameter int CW = 7,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          load,
  input  logic          step,
  input  logic [DW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic [DW-1:0] quo_nxt
);

  localparam int STEPS = (DW + 1) / 2;
  localparam int DWP   = 2 * STEPS;

  logic [DWP-1:0] dvd_r;
  logic [DWP-1:0] quo_r;
  logic [CW-1:0]  rem_r;
  logic [CW-1:0]  dsr_r;

  logic [CW:0]    t1, t2;
  logic           ge1, ge2;
  logic [CW-1:0]  r1, r2;
  logic [DWP-1:0] quo_full;

  always_comb begin
    t1  = {rem_r, dvd_r[DWP-1]};
    ge1 = t1 >= {1'b0, dsr_r};
    r1  = ge1 ? CW'(t1 - {1'b0, dsr_r}) : CW'(t1);
    t2  = {r1, dvd_r[DWP-2]};
    ge2 = t2 >= {1'b0, dsr_r};
    r2  = ge2 ? CW'(t2 - {1'b0, dsr_r}) : CW'(t2);
    quo_full = {quo_r[DWP-3:0], ge1, ge2};
  end

  assign quo_nxt = quo_full[DW-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= DWP'(dividend);
      quo_r <= '0;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (step) begin
      dvd_r <= {dvd_r[DWP-3:0], 2'b00};
      quo_r <= quo_full;
      rem_r <= r2;
    end
  end

endmodule

/* sv/ssrb_dp.sv */
// datapath: configuration registers, sprite counters, run state, edge quotients
// and the output register; uses ssrb_pkg and ssrb_div
module ssrb_dp import ssrb_pkg::*; #(
  parameter int MAX_SPRITE_DIM = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dp_cmd_t                     cmd,
  output dp_sts_t                     sts,
  input  logic [PIX_W-1:0]            in_pixel_rgb565,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_XY_W-1:0]  out_fill_x,
  output logic signed [OUT_XY_W-1:0]  out_fill_y,
  output logic [SIZE_W-1:0]           out_fill_w,
  output logic [SIZE_W-1:0]           out_fill_h,
  output logic [RGB_W-1:0]            out_fill_rgb,
  output logic                        out_last_in_burst
);

  localparam int NW = $clog2(MAX_SPRITE_DIM);
  localparam int CW = $clog2(MAX_SPRITE_DIM + 1);
  localparam int DW = CW + SPAN_W;

  // configuration
  logic signed [COORD_W-1:0] dest_left_r, dest_top_r;
  logic [SPAN_W-1:0]         span_x_r, span_y_r;
  logic [SRC_DIM_W-1:0]      src_cols_r, src_rows_r;

  // sprite walk state
  logic [NW-1:0]    col_count_r, row_count_r, run_start_r;
  logic [PIX_W-1:0] run_color_r;
  logic             run_open_r;
  logic [PIX_W-1:0] pix_r;

  // scaled edge quotients
  logic [DW-1:0] qt_r, qb_r, qs_r, qc_r, qc1_r;

  // output register
  logic                       out_valid_r;
  logic [OUT_XY_W-1:0]        fill_x_r, fill_y_r;
  logic [SIZE_W-1:0]          fill_w_r, fill_h_r;
  logic [RGB_W-1:0]           fill_rgb_r;
  logic                       last_r;

  logic [CW-1:0]     cols_eff, rows_eff;
  logic              col_last, row_last;
  logic [CW-1:0]     opnd, dsr;
  logic [SPAN_W-1:0] span;
  logic [DW-1:0]     dividend, quo_nxt;

  logic              open_new, h_pos, vis_a, vis_b, out_free;
  logic [PIX_W-1:0]  b_color;
  logic [DW-1:0]     b_q0;
  logic [OUT_XY_W-1:0] left_ext, top_ext;

  // source size clamped to 1..MAX_SPRITE_DIM
  always_comb begin
    if (src_cols_r == '0) cols_eff = CW'(1);
    else if (int'(src_cols_r) > MAX_SPRITE_DIM) cols_eff = CW'(MAX_SPRITE_DIM);
    else cols_eff = CW'(src_cols_r);
    if (src_rows_r == '0) rows_eff = CW'(1);
    else if (int'(src_rows_r) > MAX_SPRITE_DIM) rows_eff = CW'(MAX_SPRITE_DIM);
    else rows_eff = CW'(src_rows_r);
  end

  assign col_last = CW'(col_count_r) >= cols_eff - CW'(1);
  assign row_last = CW'(row_count_r) >= rows_eff - CW'(1);

  always_comb begin
    case (cmd.op)
      OP_TOP: begin
        opnd = CW'(row_count_r);
        span = span_y_r;
        dsr  = rows_eff;
      end
      OP_BOT: begin
        opnd = CW'(row_count_r) + CW'(1);
        span = span_y_r;
        dsr  = rows_eff;
      end
      OP_START: begin
        opnd = CW'(run_start_r);
        span = span_x_r;
        dsr  = cols_eff;
      end
      OP_COL: begin
        opnd = CW'(col_count_r);
        span = span_x_r;
        dsr  = cols_eff;
      end
      OP_COL1: begin
        opnd = CW'(col_count_r) + CW'(1);
        span = span_x_r;
        dsr  = cols_eff;
      end
      default: begin
        opnd = '0;
        span = span_x_r;
        dsr  = cols_eff;
      end
    endcase
  end

  // product is registered inside the divider on load
  assign dividend = DW'(opnd) * DW'(span);

  ssrb_div #(
    .CW (CW),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .load     (cmd.load),
    .step     (cmd.step),
    .dividend (dividend),
    .divisor  (dsr),
    .quo_nxt  (quo_nxt)
  );

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.op)
        OP_TOP:   qt_r  <= quo_nxt;
        OP_BOT:   qb_r  <= quo_nxt;
        OP_START: qs_r  <= quo_nxt;
        OP_COL:   qc_r  <= quo_nxt;
        OP_COL1:  qc1_r <= quo_nxt;
        default: ;
      endcase
    end
    if (cmd.take) begin
      pix_r <= in_pixel_rgb565;
    end
  end

  // run closed by a colour change, and run closed by the row end
  always_comb begin
    open_new = !run_open_r || (pix_r != run_color_r);
    h_pos    = qb_r > qt_r;
    vis_a    = run_open_r && open_new && (run_color_r != '0) && (qc_r > qs_r) && h_pos;
    b_color  = open_new ? pix_r : run_color_r;
    b_q0     = open_new ? qc_r : qs_r;
    vis_b    = col_last && (b_color != '0) && (qc1_r > b_q0) && h_pos;
    left_ext = {dest_left_r[COORD_W-1], dest_left_r};
    top_ext  = {dest_top_r[COORD_W-1], dest_top_r};
  end

  assign out_free = !out_valid_r || !out_stall;
  assign sts.vis_a    = vis_a;
  assign sts.vis_b    = vis_b;
  assign sts.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_a || cmd.emit_b) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_a) begin
      fill_x_r   <= left_ext + OUT_XY_W'(qs_r);
      fill_w_r   <= SIZE_W'(qc_r - qs_r);
      fill_rgb_r <= widen565(run_color_r);
      last_r     <= !vis_b;
    end else if (cmd.emit_b) begin
      fill_x_r   <= left_ext + OUT_XY_W'(b_q0);
      fill_w_r   <= SIZE_W'(qc1_r - b_q0);
      fill_rgb_r <= widen565(b_color);
      last_r     <= 1'b1;
    end
    if (cmd.emit_a || cmd.emit_b) begin
      fill_y_r <= top_ext + OUT_XY_W'(qt_r);
      fill_h_r <= SIZE_W'(qb_r - qt_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fill_x        = fill_x_r;
  assign out_fill_y        = fill_y_r;
  assign out_fill_w        = fill_w_r;
  assign out_fill_h        = fill_h_r;
  assign out_fill_rgb      = fill_rgb_r;
  assign out_last_in_burst = last_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_left_r <= '0;
      dest_top_r  <= '0;
      span_x_r    <= '0;
      span_y_r    <= '0;
      src_cols_r  <= SRC_DIM_W'(1);
      src_rows_r  <= SRC_DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEST_LEFT:   dest_left_r <= cfg_data;
        REG_DEST_TOP:    dest_top_r  <= cfg_data;
        REG_DEST_SPAN_X: span_x_r    <= cfg_data[SPAN_W-1:0];
        REG_DEST_SPAN_Y: span_y_r    <= cfg_data[SPAN_W-1:0];
        REG_SRC_COLS:    src_cols_r  <= cfg_data[SRC_DIM_W-1:0];
        REG_SRC_ROWS:    src_rows_r  <= cfg_data[SRC_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // counters and run state advance when the pixel's last fill request is loaded, or when none is due
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      run_start_r <= '0;
      run_color_r <= '0;
      run_open_r  <= 1'b0;
    end else if (cmd.update) begin
      if (open_new) begin
        run_start_r <= col_count_r;
        run_color_r <= pix_r;
      end
      run_open_r <= !col_last;
      if (col_last) begin
        col_count_r <= '0;
        row_count_r <= row_last ? '0 : row_count_r + NW'(1);
      end else begin
        col_count_r <= col_count_r + NW'(1);
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_a || cmd.emit_b) |-> (!out_valid_r || !out_stall))
    else $error("output register loaded while a request waits");

  // height is masked to its field and may wrap to zero after a size change
  a_nonempty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (fill_h_r != '0))
    else $error("fill rectangle of zero height presented");

  a_run_start_order: assert property (@(posedge clk) disable iff (!rst_n)
    run_open_r |-> (run_start_r <= col_count_r))
    else $error("open run starts after the current column");

endmodule

/* sv/ssrb_ctrl.sv */
// controller: sequences five divisions per pixel, then up to two fill requests
// uses ssrb_pkg; drives the ssrb_dp command bundle
module ssrb_ctrl import ssrb_pkg::*; #(
  parameter int MAX_SPRITE_DIM = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  localparam int CW    = $clog2(MAX_SPRITE_DIM + 1);
  localparam int DW    = CW + SPAN_W;
  localparam int STEPS = (DW + 1) / 2;
  localparam int SCW   = $clog2(STEPS);

  state_t         state_r, state_nxt;
  op_t            op_r, op_nxt;
  logic [SCW-1:0] step_r, step_nxt;

  always_comb begin
    cmd       = '0;
    cmd.op    = op_r;
    state_nxt = state_r;
    op_nxt    = op_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          op_nxt    = OP_TOP;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (step_r == SCW'(STEPS - 1)) begin
          cmd.store = 1'b1;
          state_nxt = S_LOAD;
          case (op_r)
            OP_TOP:   op_nxt = OP_BOT;
            OP_BOT:   op_nxt = OP_START;
            OP_START: op_nxt = OP_COL;
            OP_COL:   op_nxt = OP_COL1;
            default:  state_nxt = S_EMIT_A;
          endcase
        end else begin
          step_nxt = step_r + SCW'(1);
        end
      end
      S_EMIT_A: begin
        if (!sts.vis_a) begin
          state_nxt = S_EMIT_B;
        end else if (sts.out_free) begin
          cmd.emit_a = 1'b1;
          state_nxt  = S_EMIT_B;
        end
      end
      S_EMIT_B: begin
        if (!sts.vis_b) begin
          cmd.update = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_b = 1'b1;
          cmd.update = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_TOP;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

/* sv/scaled_sprite_run_blitter.sv */
// Scaled sprite run blitter. Takes RGB565 sprite pixels in raster order and
// turns each horizontal run of equal colour into one fill rectangle on the
// destination, with edges at dest + index*span/size and the colour widened to
// RGB888; colour zero and empty rectangles give nothing, and one pixel gives at
// most two requests, the last one flagged. A pixel is taken only while the
// block is idle, and the block is ready for the next once the five scaled
// edges (row, row + 1, run start, column, column + 1) have gone one after
// another through a single radix-4 divider, a load and S steps each, with
// S = ceil((clog2(MAX_SPRITE_DIM+1) + 11) / 2), and its requests have been
// loaded into the output register, which waits on a stalled output. A request
// waiting in the output register does not block acceptance of the next pixel.
// Configuration is taken at any cycle and must only change while idle.
// depends on ssrb_pkg, ssrb_ctrl, ssrb_dp
module scaled_sprite_run_blitter import ssrb_pkg::*; #(
  parameter int MAX_SPRITE_DIM = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [PIX_W-1:0]           in_pixel_rgb565,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_XY_W-1:0] out_fill_x,
  output logic signed [OUT_XY_W-1:0] out_fill_y,
  output logic [SIZE_W-1:0]          out_fill_w,
  output logic [SIZE_W-1:0]          out_fill_h,
  output logic [RGB_W-1:0]           out_fill_rgb,
  output logic                       out_last_in_burst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  ssrb_ctrl #(
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  ssrb_dp #(
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_pixel_rgb565   (in_pixel_rgb565),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fill_x        (out_fill_x),
    .out_fill_y        (out_fill_y),
    .out_fill_w        (out_fill_w),
    .out_fill_h        (out_fill_h),
    .out_fill_rgb      (out_fill_rgb),
    .out_last_in_burst (out_last_in_burst)
  );

endmodule
